// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Holds macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define VLN_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define VLN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vln_pkg.sv =====
// Shared types and constants of the vector length and normalise block.
// No dependencies.
package vln_pkg;

    localparam int FRAC_UNIT   = 14;   // fraction bits of a unit component
    localparam int QUOT_W      = 15;   // quotient bits, covers 0..16384
    localparam int UNIT_W      = 16;
    localparam int LEN_OUT_W   = 16;
    localparam int SQ_OUT_W    = 32;
    localparam int THR_W       = 8;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Register word indexes on the configuration port
    localparam logic REG_ZERO_THRESHOLD = 1'b0;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd1;

    // Per-stage control handed to every pipeline step
    typedef struct packed {
        logic advance;
        logic valid;
    } stage_ctl_t;

endpackage

// ===== design/vln_sqrt_step.sv =====
// One registered step of the digit-by-digit square root (one result bit).
// Depends on vln_pkg.
module vln_sqrt_step #(
    parameter int W    = 16,
    parameter int SB_W = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  vln_pkg::stage_ctl_t     ctl_in,
    input  logic [2*W-1:0]          n_in,
    input  logic [W+1:0]            rem_in,
    input  logic [W-1:0]            root_in,
    input  logic [SB_W-1:0]         side_in,
    output logic                    valid_out,
    output logic [2*W-1:0]          n_out,
    output logic [W+1:0]            rem_out,
    output logic [W-1:0]            root_out,
    output logic [SB_W-1:0]         side_out
);
    import vln_pkg::*;

    logic           valid_reg;
    logic [2*W-1:0] n_reg;
    logic [W+1:0]   rem_reg;
    logic [W-1:0]   root_reg;
    logic [SB_W-1:0] side_reg;

    logic [W+1:0]   rem_sh;
    logic [W+1:0]   trial;
    logic           take;
    logic [W+1:0]   rem_next;
    logic [W-1:0]   root_next;
    logic [2*W-1:0] n_next;

    // Bring down the next two bits and try root*4+1
    always_comb
    begin
        rem_sh    = {rem_in[W-1:0], n_in[2*W-1:2*W-2]};
        trial     = {root_in, 2'b01};
        take      = (rem_sh >= trial);
        rem_next  = take ? (rem_sh - trial) : rem_sh;
        root_next = {root_in[W-2:0], take};
        n_next    = {n_in[2*W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl_in.advance)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.advance)
        begin
            n_reg    <= n_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign n_out     = n_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;

endmodule

// ===== design/vln_div_step.sv =====
// One registered restoring-division step for the three lanes (one quotient bit).
// Depends on vln_pkg.
module vln_div_step #(
    parameter int W     = 16,
    parameter int SB_W  = 8,
    parameter bit FIRST = 1'b0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vln_pkg::stage_ctl_t           ctl_in,
    input  logic [W-1:0]                  len_in,
    input  logic [2:0][W:0]               rem_in,
    input  logic [2:0][vln_pkg::QUOT_W-1:0] q_in,
    input  logic [SB_W-1:0]               side_in,
    output logic                          valid_out,
    output logic [W-1:0]                  len_out,
    output logic [2:0][W:0]               rem_out,
    output logic [2:0][vln_pkg::QUOT_W-1:0] q_out,
    output logic [SB_W-1:0]               side_out
);
    import vln_pkg::*;

    logic                    valid_reg;
    logic [W-1:0]            len_reg;
    logic [2:0][W:0]         rem_reg;
    logic [2:0][QUOT_W-1:0]  q_reg;
    logic [SB_W-1:0]         side_reg;

    logic [2:0][W:0]         rem_next;
    logic [2:0][QUOT_W-1:0]  q_next;

    // Shift the partial remainder (not on the first step), compare, subtract
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [W:0] r;
            logic       ge;
            r  = FIRST ? rem_in[i] : {rem_in[i][W-1:0], 1'b0};
            ge = (r >= {1'b0, len_in});
            rem_next[i] = ge ? (r - {1'b0, len_in}) : r;
            q_next[i]   = {q_in[i][QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl_in.advance)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.advance)
        begin
            len_reg  <= len_in;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign len_out   = len_reg;
    assign rem_out   = rem_reg;
    assign q_out     = q_reg;
    assign side_out  = side_reg;

endmodule

// ===== design/vector3_length_normalize.sv =====
// Vector length and normalise: one signed 3D vector in, squared length, length
// and unit vector out. Depends on vln_pkg, vln_sqrt_step and vln_div_step.
//
// Usage
//   Input request: comp_x/comp_y/comp_z, taken on a clock edge with in_valid high
//   and in_stall low. Output request: length_squared, length, unit_x/y/z and
//   was_zero, taken with out_valid high and out_stall low.
//   From the accepting edge to out_valid a vector passes COMPONENT_WIDTH + 19
//   register stages: three front stages (magnitude, square, sum), one
//   square-root stage per result bit (COMPONENT_WIDTH), one division stage
//   per quotient bit (15, three lanes side by side) and the output register;
//   the first stage captures on the accepting edge itself.
//   Throughput is one vector per cycle while not stalled; every stage is a
//   register step. While the receiver stalls a held result, the whole pipeline
//   freezes and in_stall rises in the same cycle; nothing is lost or repeated.
//   The threshold register sits at byte address 0 of the APB port and is
//   sampled as items pass the length compare; write it only while idle.
//   Reset clears every valid bit and sets the threshold to 1.
module vector3_length_normalize #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vln_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [vln_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [vln_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COMPONENT_WIDTH-1:0]  comp_x,
    input  logic signed [COMPONENT_WIDTH-1:0]  comp_y,
    input  logic signed [COMPONENT_WIDTH-1:0]  comp_z,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [vln_pkg::SQ_OUT_W-1:0]       length_squared,
    output logic [vln_pkg::LEN_OUT_W-1:0]      length,
    output logic signed [vln_pkg::UNIT_W-1:0]  unit_x,
    output logic signed [vln_pkg::UNIT_W-1:0]  unit_y,
    output logic signed [vln_pkg::UNIT_W-1:0]  unit_z,
    output logic                               was_zero
);
    import vln_pkg::*;

    localparam int CW     = COMPONENT_WIDTH;
    localparam int SW     = 2 * CW;                 // exact sum of three squares
    localparam int SB_S   = 3 + 3 * CW + SW;         // neg, mags, sum
    localparam int SB_D   = 1 + 3 + SQ_OUT_W + LEN_OUT_W;
    localparam int SUMX_W = SW + SQ_OUT_W;
    localparam int LENX_W = CW + LEN_OUT_W;
    localparam logic [SUMX_W-1:0] SQ_MAX  = SUMX_W'({SQ_OUT_W{1'b1}});
    localparam logic [LENX_W-1:0] LEN_MAX = LENX_W'({LEN_OUT_W{1'b1}});

    // ---------------- configuration ----------------
    logic [THR_W-1:0] threshold_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write && (paddr[APB_ADDR_W-1] == REG_ZERO_THRESHOLD))
        begin
            threshold_reg <= pwdata[THR_W-1:0];
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1] == REG_ZERO_THRESHOLD) ?
                    APB_DATA_W'(threshold_reg) : '0;

    // ---------------- flow control ----------------
    // Freeze every stage while a finished result is held by the receiver.
    logic       out_valid_reg;
    logic       advance;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // ---------------- stage 0: sign and magnitude ----------------
    logic [COMPONENT_WIDTH-1:0] comp_in [3];
    logic [2:0]                 s0_valid_vec;
    logic                       s0_valid_reg;
    logic [2:0]                 s0_neg_reg;
    logic [2:0][CW-1:0]         s0_mag_reg;

    assign comp_in[0] = comp_x;
    assign comp_in[1] = comp_y;
    assign comp_in[2] = comp_z;
    assign s0_valid_vec = {3{in_valid}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= s0_valid_vec[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s0_neg_reg[i] <= comp_in[i][CW-1];
                s0_mag_reg[i] <= comp_in[i][CW-1] ? (CW'(0) - comp_in[i]) : comp_in[i];
            end
        end
    end

    // ---------------- stage 1: squares ----------------
    logic               s1_valid_reg;
    logic [2:0]         s1_neg_reg;
    logic [2:0][CW-1:0] s1_mag_reg;
    logic [2:0][SW-1:0] s1_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_neg_reg <= s0_neg_reg;
            s1_mag_reg <= s0_mag_reg;
            for (int i = 0; i < 3; i++)
            begin
                s1_sq_reg[i] <= SW'(s0_mag_reg[i]) * SW'(s0_mag_reg[i]);
            end
        end
    end

    // ---------------- stage 2: sum of squares ----------------
    logic               s2_valid_reg;
    logic [SW-1:0]      s2_sum_reg;
    logic [2:0]         s2_neg_reg;
    logic [2:0][CW-1:0] s2_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_sum_reg <= s1_sq_reg[0] + s1_sq_reg[1] + s1_sq_reg[2];
            s2_neg_reg <= s1_neg_reg;
            s2_mag_reg <= s1_mag_reg;
        end
    end

    // ---------------- square root: one bit per stage ----------------
    stage_ctl_t        sq_ctl  [CW];
    logic              sq_vld  [CW+1];
    logic [SW-1:0]     sq_n    [CW+1];
    logic [CW+1:0]     sq_rem  [CW+1];
    logic [CW-1:0]     sq_root [CW+1];
    logic [SB_S-1:0]   sq_side [CW+1];

    assign sq_vld[0]  = s2_valid_reg;
    assign sq_n[0]    = s2_sum_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = {s2_neg_reg, s2_mag_reg, s2_sum_reg};

    for (genvar k = 0; k < CW; k++)
    begin : g_sqrt
        assign sq_ctl[k] = '{advance: advance, valid: sq_vld[k]};

        vln_sqrt_step #(
            .W    (CW),
            .SB_W (SB_S)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (sq_ctl[k]),
            .n_in      (sq_n[k]),
            .rem_in    (sq_rem[k]),
            .root_in   (sq_root[k]),
            .side_in   (sq_side[k]),
            .valid_out (sq_vld[k+1]),
            .n_out     (sq_n[k+1]),
            .rem_out   (sq_rem[k+1]),
            .root_out  (sq_root[k+1]),
            .side_out  (sq_side[k+1])
        );
    end

    // ---------------- length compare and saturation ----------------
    logic [2:0]         lc_neg;
    logic [2:0][CW-1:0] lc_mag;
    logic [SW-1:0]      lc_sum;
    logic [CW-1:0]      lc_len;
    logic [SUMX_W-1:0]  lc_sum_ext;
    logic [LENX_W-1:0]  lc_len_ext;
    logic               lc_zero;
    logic [SQ_OUT_W-1:0]  lc_sq_sat;
    logic [LEN_OUT_W-1:0] lc_len_sat;

    always_comb
    begin
        {lc_neg, lc_mag, lc_sum} = sq_side[CW];
        lc_len     = sq_root[CW];
        lc_zero    = (lc_len == '0) || (lc_len < CW'(threshold_reg));
        lc_sum_ext = SUMX_W'(lc_sum);
        lc_len_ext = LENX_W'(lc_len);
        lc_sq_sat  = (lc_sum_ext > SQ_MAX) ? {SQ_OUT_W{1'b1}} : lc_sum_ext[SQ_OUT_W-1:0];
        lc_len_sat = (lc_len_ext > LEN_MAX) ? {LEN_OUT_W{1'b1}} : lc_len_ext[LEN_OUT_W-1:0];
    end

    // ---------------- division: one quotient bit per stage ----------------
    stage_ctl_t              dv_ctl  [QUOT_W];
    logic                    dv_vld  [QUOT_W+1];
    logic [CW-1:0]           dv_len  [QUOT_W+1];
    logic [2:0][CW:0]        dv_rem  [QUOT_W+1];
    logic [2:0][QUOT_W-1:0]  dv_q    [QUOT_W+1];
    logic [SB_D-1:0]         dv_side [QUOT_W+1];

    assign dv_vld[0]  = sq_vld[CW];
    assign dv_len[0]  = lc_len;
    assign dv_q[0]    = '0;
    assign dv_side[0] = {lc_zero, lc_neg, lc_sq_sat, lc_len_sat};

    for (genvar i = 0; i < 3; i++)
    begin : g_rem_init
        assign dv_rem[0][i] = {1'b0, lc_mag[i]};
    end

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_div
        assign dv_ctl[k] = '{advance: advance, valid: dv_vld[k]};

        vln_div_step #(
            .W     (CW),
            .SB_W  (SB_D),
            .FIRST (k == 0)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (dv_ctl[k]),
            .len_in    (dv_len[k]),
            .rem_in    (dv_rem[k]),
            .q_in      (dv_q[k]),
            .side_in   (dv_side[k]),
            .valid_out (dv_vld[k+1]),
            .len_out   (dv_len[k+1]),
            .rem_out   (dv_rem[k+1]),
            .q_out     (dv_q[k+1]),
            .side_out  (dv_side[k+1])
        );
    end

    // ---------------- output register ----------------
    logic                 fin_zero;
    logic [2:0]           fin_neg;
    logic [SQ_OUT_W-1:0]  fin_sq;
    logic [LEN_OUT_W-1:0] fin_len;
    logic [2:0][UNIT_W-1:0] unit_next;

    logic [SQ_OUT_W-1:0]    length_squared_reg;
    logic [LEN_OUT_W-1:0]   length_reg;
    logic [2:0][UNIT_W-1:0] unit_reg;
    logic                   was_zero_reg;

    // Apply sign, and drop to zero for a zero length or one below the threshold
    always_comb
    begin
        {fin_zero, fin_neg, fin_sq, fin_len} = dv_side[QUOT_W];
        for (int i = 0; i < 3; i++)
        begin
            if (fin_zero)
            begin
                unit_next[i] = '0;
            end
            else if (fin_neg[i])
            begin
                unit_next[i] = UNIT_W'(0) - UNIT_W'(dv_q[QUOT_W][i]);
            end
            else
            begin
                unit_next[i] = UNIT_W'(dv_q[QUOT_W][i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= dv_vld[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            length_squared_reg <= fin_sq;
            length_reg         <= fin_len;
            unit_reg           <= unit_next;
            was_zero_reg       <= fin_zero;
        end
    end

    assign out_valid      = out_valid_reg;
    assign length_squared = length_squared_reg;
    assign length         = length_reg;
    assign unit_x         = unit_reg[0];
    assign unit_y         = unit_reg[1];
    assign unit_z         = unit_reg[2];
    assign was_zero       = was_zero_reg;

endmodule

// ===== design/vln_checker.sv =====
// Port-level checks for the vector length and normalise block, bound to its top.
// Depends on vln_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vln_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [vln_pkg::LEN_OUT_W-1:0]     length,
    input logic signed [vln_pkg::UNIT_W-1:0] unit_x,
    input logic signed [vln_pkg::UNIT_W-1:0] unit_y,
    input logic signed [vln_pkg::UNIT_W-1:0] unit_z,
    input logic                              was_zero
);
    import vln_pkg::*;

    // Input backpressure only ever comes from a held result
    `VLN_ASSERT_IMPLY(a_stall_source, clk, rst_n, in_stall, out_valid && out_stall, "in_stall without held result")

    // A zero result carries a zero unit vector
    `VLN_ASSERT_IMPLY(a_zero_unit, clk, rst_n, out_valid && was_zero, (unit_x == '0) && (unit_y == '0) && (unit_z == '0), "nonzero unit on zero vector")

    // A normalised result never has zero length
    `VLN_ASSERT_IMPLY(a_len_nonzero, clk, rst_n, out_valid && !was_zero, length != '0, "zero length not flagged")

    // A held result stays offered
    `VLN_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

endmodule

bind vector3_length_normalize vln_checker u_vln_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .length    (length),
    .unit_x    (unit_x),
    .unit_y    (unit_y),
    .unit_z    (unit_z),
    .was_zero  (was_zero)
);

// ===== bench/testbench.sv =====
// Self-checking bench for vector3_length_normalize: directed table, threshold extremes, then random vectors.
// Depends on vln_pkg and the vector3_length_normalize RTL.
module testbench;
    import vln_pkg::*;

    localparam int CW         = 16;
    localparam int LATENCY    = CW + 18;
    localparam int CYCLE_MAX  = 400000;
    localparam int RANDOM_N   = 270;
    localparam int N_DIRECTED = 14;

    // Result bundle that one request produces
    typedef struct packed {
        logic [SQ_OUT_W-1:0]      sq;
        logic [LEN_OUT_W-1:0]     len;
        logic signed [UNIT_W-1:0] ux;
        logic signed [UNIT_W-1:0] uy;
        logic signed [UNIT_W-1:0] uz;
        logic                     zero;
    } norm_result_t;

    // Directed request; has_fixed marks rows whose result is typed in
    typedef struct {
        logic signed [CW-1:0] x, y, z;
        logic                 has_fixed;
        norm_result_t         fixed;
    } vec_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0]    pwdata = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [CW-1:0]     comp_x = '0, comp_y = '0, comp_z = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [SQ_OUT_W-1:0]      length_squared;
    logic [LEN_OUT_W-1:0]     length;
    logic signed [UNIT_W-1:0] unit_x, unit_y, unit_z;
    logic                     was_zero;

    norm_result_t     pending_results[$];
    logic [THR_W-1:0] threshold_shadow;
    int               error_count = 0;
    int               cycle_count = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    bit               hold_off = 1'b0;
    int               hold_off_cycles = 0;

    vector3_length_normalize #(.COMPONENT_WIDTH(CW)) i_dut (.*);

    always #10 clk = ~clk;

    // Truncated integer square root, one result bit per pass
    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Work out length, squared length and unit vector of one request
    function automatic norm_result_t normalise(input logic signed [CW-1:0] x,
                                               input logic signed [CW-1:0] y,
                                               input logic signed [CW-1:0] z);
        norm_result_t r;
        logic [63:0]  mag[3];
        logic         neg[3];
        logic [63:0]  sum;
        logic [63:0]  len;
        logic [63:0]  q;
        logic signed [CW-1:0] c[3];
        c[0] = x; c[1] = y; c[2] = z;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = c[i][CW-1];
            mag[i] = neg[i] ? 64'((~{1'b0, c[i]} + 1) & ((1 << CW) - 1))
                            : 64'(c[i]) & ((64'd1 << CW) - 1);
            sum += mag[i] * mag[i];
        end
        len    = int_sqrt(sum);
        r.zero = (len == 0) || (len < threshold_shadow);
        r.sq   = (sum > 64'hFFFF_FFFF) ? '1 : sum[SQ_OUT_W-1:0];
        r.len  = (len > 64'hFFFF) ? '1 : len[LEN_OUT_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            q = 0;
            if (!r.zero)
            begin
                q = (mag[i] << FRAC_UNIT) / len;
                if (neg[i]) q = 64'd0 - q;
            end
            case (i)
                0: r.ux = q[UNIT_W-1:0];
                1: r.uy = q[UNIT_W-1:0];
                default: r.uz = q[UNIT_W-1:0];
            endcase
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    // Run the APB setup and access cycles for one register write
    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(posedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= APB_ADDR_W'(REG_ZERO_THRESHOLD) << 2;
        pwdata <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        threshold_shadow = value;
    endtask

    // Offer one request and hold it until taken; optional gap before it
    task automatic send_vector(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                               input logic signed [CW-1:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        comp_x   <= x;
        comp_y   <= y;
        comp_z   <= z;
        pending_results.push_back(normalise(x, y, z));
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid and wait for the pipeline to drain
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_phase(input int n, input int s_pct, input int r_pct);
        logic signed [CW-1:0] v[3];
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                case ($urandom_range(3))
                    0: v[i] = CW'($urandom);
                    1: v[i] = CW'($signed($urandom_range(0, 15)) - 8);
                    2: v[i] = CW'($signed($urandom_range(0, 1023)) - 512);
                    default: v[i] = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                endcase
            end
            send_vector(v[0], v[1], v[2]);
        end
        drain();
    endtask

    // Receiver stall: random, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_off && hold_off_cycles < 60)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles + 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        norm_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report("unexpected result", 64'd1, 64'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (length_squared !== want.sq) report("length_squared", length_squared, want.sq);
                if (length !== want.len)        report("length", length, want.len);
                if (unit_x !== want.ux)         report("unit_x", unit_x, want.ux);
                if (unit_y !== want.uy)         report("unit_y", unit_y, want.uy);
                if (unit_z !== want.uz)         report("unit_z", unit_z, want.uz);
                if (was_zero !== want.zero)     report("was_zero", was_zero, want.zero);
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        vec_row_t    rows[N_DIRECTED];
        logic [7:0]  thr_set[4];
        norm_result_t fixed_r;
        threshold_shadow = THRESHOLD_RESET;

        // Directed table: zero vector, unit axes, extremes, small lengths
        rows[0]  = '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{0, 0, 0, 0, 0, 1'b1}};
        rows[1]  = '{16'sd256, 16'sd0, 16'sd0, 1'b1, '{65536, 256, 16384, 0, 0, 1'b0}};
        rows[2]  = '{16'sd0, -16'sd256, 16'sd0, 1'b1, '{65536, 256, 0, -16384, 0, 1'b0}};
        rows[3]  = '{16'sd0, 16'sd0, 16'sd1, 1'b1, '{1, 1, 0, 0, 16384, 1'b0}};
        rows[4]  = '{16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
                     '{32'hC000_0000, 16'd56755, 0, 0, 0, 1'b0}};
        rows[5]  = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, '{0, 0, 0, 0, 0, 1'b0}};
        rows[6]  = '{16'sh8000, 16'sh7FFF, 16'sd0, 1'b0, '{0, 0, 0, 0, 0, 1'b0}};
        rows[7]  = '{-16'sd1, -16'sd1, -16'sd1, 1'b0, '{0, 0, 0, 0, 0, 1'b0}};
        rows[8]  = '{16'sd3, 16'sd4, 16'sd0, 1'b0, '{0, 0, 0, 0, 0, 1'b0}};
        rows[9]  = '{16'sh5555, -16'sh2AAA, 16'sh0F0F, 1'b0, '{0, 0, 0, 0, 0, 1'b0}};
        rows[10] = '{16'sh0001, 16'sh0002, 16'sh0004, 1'b0, '{0, 0, 0, 0, 0, 1'b0}};
        rows[11] = '{16'sh4000, 16'sh2000, -16'sh1000, 1'b0, '{0, 0, 0, 0, 0, 1'b0}};
        rows[12] = '{-16'sh7FFF, 16'sh00FF, 16'sh0100, 1'b0, '{0, 0, 0, 0, 0, 1'b0}};
        rows[13] = '{16'sd10, -16'sd10, 16'sd10, 1'b0, '{0, 0, 0, 0, 0, 1'b0}};
        // The all-most-negative row: unit = -(32768<<14)/56755 per lane
        rows[4].fixed.ux = -16'sd9459;
        rows[4].fixed.uy = -16'sd9459;
        rows[4].fixed.uz = -16'sd9459;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset threshold; typed-in rows override the predictor
        foreach (rows[i])
        begin
            send_vector(rows[i].x, rows[i].y, rows[i].z);
            if (rows[i].has_fixed)
            begin
                fixed_r = rows[i].fixed;
                void'(pending_results.pop_back());
                pending_results.push_back(fixed_r);
            end
        end
        drain();

        // Threshold extremes, with thresholds caught around small lengths
        thr_set = '{8'd0, 8'd255, 8'd16, 8'd1};
        foreach (thr_set[t])
        begin
            write_threshold(thr_set[t]);
            for (int k = 0; k < 6; k++)
                send_vector(CW'(k * 3), 16'sd0, 16'sd0);
            send_vector(16'sd0, CW'(thr_set[t]), 16'sd0);
            send_vector(16'sd0, 16'sd0, CW'(thr_set[t] - 1));
            drain();
        end

        // Long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        random_phase(LATENCY * 2 + 20, 0, 0);
        hold_off = 1'b0;

        write_threshold(8'd200);
        random_phase(RANDOM_N / 3, 9, 50);
        write_threshold(8'd0);
        random_phase(RANDOM_N / 3, 50, 9);
        write_threshold(8'd255);
        random_phase(RANDOM_N / 3, 0, 0);

        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
